>>> rtl/jse_pkg.sv
// Package for the JSON string escaper: item structs, queue entry, constants.
// Shared by the front, queue, back and top-level modules; depends on nothing.
package jse_pkg;

    localparam int MAX_STRING_LEN = 4096;
    localparam int LEN_W = 15;
    localparam int LEN_CAP_RAW = 6 * MAX_STRING_LEN;
    localparam int LEN_CAP = (LEN_CAP_RAW > 32767) ? 32767 : LEN_CAP_RAW;

    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_B = 8'h62;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_LOW_N = 8'h6E;
    localparam logic [7:0] CH_LOW_R = 8'h72;
    localparam logic [7:0] CH_LOW_T = 8'h74;
    localparam logic [7:0] CH_LOW_U = 8'h75;

    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] IDX_FIRST = 3'd0;
    localparam logic [IDX_W-1:0] IDX_SHORT_LAST = 3'd1;
    localparam logic [IDX_W-1:0] IDX_U = 3'd1;
    localparam logic [IDX_W-1:0] IDX_ZERO_HI = 3'd2;
    localparam logic [IDX_W-1:0] IDX_ZERO_LO = 3'd3;
    localparam logic [IDX_W-1:0] IDX_HEX_HI = 3'd4;
    localparam logic [IDX_W-1:0] IDX_UNI_LAST = 3'd5;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_SHORT,
        KIND_UNI
    } t_kind;

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       out_char;
        logic             run_last;
        logic             string_done;
        logic [LEN_W-1:0] escaped_length;
    } t_out_item;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       eos;
    } t_entry;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = CH_ZERO + {4'd0, nib};
        end else begin
            r = CH_LOW_A + {4'd0, nib} - 8'd10;
        end
        return r;
    endfunction

endpackage

>>> rtl/jse_front.sv
// Front end: classifies each raw byte into a queue entry (pass, two-byte or six-byte escape).
// Depends on jse_pkg.
module jse_front (
    input  jse_pkg::t_in_item i_item,
    output jse_pkg::t_entry   o_entry
);
    import jse_pkg::*;

    logic [7:0] letter;
    logic       is_short;

    always_comb begin
        is_short = 1'b1;
        letter = i_item.raw_byte;
        unique case (i_item.raw_byte)
            CH_QUOTE:  letter = CH_QUOTE;
            CH_SLASH:  letter = CH_SLASH;
            CH_BSLASH: letter = CH_BSLASH;
            CH_BS:     letter = CH_LOW_B;
            CH_FF:     letter = CH_LOW_F;
            CH_NL:     letter = CH_LOW_N;
            CH_CR:     letter = CH_LOW_R;
            CH_TAB:    letter = CH_LOW_T;
            default:   is_short = 1'b0;
        endcase

        o_entry.eos = i_item.end_of_string;
        if (is_short) begin
            o_entry.kind = KIND_SHORT;
            o_entry.data = letter;
        end else if (i_item.raw_byte < CTRL_LIMIT) begin
            o_entry.kind = KIND_UNI;
            o_entry.data = i_item.raw_byte;
        end else begin
            o_entry.kind = KIND_PASS;
            o_entry.data = i_item.raw_byte;
        end
    end

endmodule

>>> rtl/jse_queue.sv
// Short queue of classified entries between the front and back parts.
// Depends on jse_pkg.
module jse_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jse_pkg::t_entry  i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output jse_pkg::t_entry  o_entry
);
    import jse_pkg::*;

    t_entry           r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QAW'(r_wr_ptr - r_rd_ptr) == QAW'(r_count))
        else $error("queue pointers disagree with count");
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !do_pop)
        else $error("pop from empty queue");

endmodule

>>> rtl/jse_back.sv
// Back end: expands each queued entry into its escaped bytes and keeps the running length.
// Depends on jse_pkg; drives the registered output item.
module jse_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  jse_pkg::t_entry    i_q_entry,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output jse_pkg::t_out_item o_out_data
);
    import jse_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] len_inc;
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;
    logic             step;
    logic             last;
    logic [7:0]       ch;

    assign step = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop = step && last;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    always_comb begin
        unique case (i_q_entry.kind)
            KIND_PASS:  last = 1'b1;
            KIND_SHORT: last = (r_idx == IDX_SHORT_LAST);
            KIND_UNI:   last = (r_idx == IDX_UNI_LAST);
            default:    last = 1'b1;
        endcase

        ch = CH_BSLASH;
        unique case (i_q_entry.kind)
            KIND_PASS: ch = i_q_entry.data;
            KIND_SHORT: begin
                ch = (r_idx == IDX_FIRST) ? CH_BSLASH : i_q_entry.data;
            end
            KIND_UNI: begin
                unique case (r_idx)
                    IDX_FIRST:    ch = CH_BSLASH;
                    IDX_U:        ch = CH_LOW_U;
                    IDX_ZERO_HI:  ch = CH_ZERO;
                    IDX_ZERO_LO:  ch = CH_ZERO;
                    IDX_HEX_HI:   ch = hex_digit(i_q_entry.data[7:4]);
                    IDX_UNI_LAST: ch = hex_digit(i_q_entry.data[3:0]);
                    default:      ch = CH_BSLASH;
                endcase
            end
            default: ch = i_q_entry.data;
        endcase

        len_inc = (r_len < LEN_W'(LEN_CAP)) ? r_len + 1'b1 : r_len;

        n_out.out_char       = ch;
        n_out.run_last       = last;
        n_out.string_done    = last && i_q_entry.eos;
        n_out.escaped_length = len_inc;

        n_idx = r_idx;
        n_len = r_len;
        if (step) begin
            n_idx = last ? IDX_FIRST : r_idx + 1'b1;
            n_len = (last && i_q_entry.eos) ? '0 : len_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= IDX_FIRST;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_len <= n_len;
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_UNI_LAST)
        else $error("byte index out of range");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.string_done || r_out.run_last))
        else $error("string end flagged on a byte that is not the last of its item");
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.escaped_length != '0
                         && r_out.escaped_length <= LEN_W'(LEN_CAP)))
        else $error("escaped length out of range");
    a_idx_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_idx == IDX_FIRST))
        else $error("byte index not cleared after an item completes");

endmodule

>>> rtl/json_string_escaper_unit.sv
// Top level of the JSON string escaper: front classifier, entry queue and back expander.
// Depends on jse_pkg, jse_front, jse_queue and jse_back.
//
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_ready    i_in_data  (raw_byte, end_of_string)
//  out      output     o_out_valid / i_out_ready  o_out_data (out_char, run_last,
//                                                  string_done, escaped_length)
//
// The back part emits one escaped byte per cycle unless the output stalls.
// Input items enter one per cycle until the four-entry queue fills.
// An item gives 1, 2 or 6 bytes; it is held in the queue, then in the output register.
// Reset is synchronous and clears the queue, the byte index and the length count.
// A stall on the output holds the output register; the queue keeps taking items.
module json_string_escaper_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  jse_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output jse_pkg::t_out_item o_out_data
);
    import jse_pkg::*;

    t_entry front_entry;
    t_entry q_entry;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;

    assign o_in_ready = !q_full;

    jse_front u_front (
        .i_item  (i_in_data),
        .o_entry (front_entry)
    );

    jse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    jse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> test/testbench.sv
// Self-checking testbench for json_string_escaper_unit: directed table, random strings and
// one long output hold-off that backs up the queue, all checked against a local model.
// Depends on jse_pkg and json_string_escaper_unit.
module testbench;
    import jse_pkg::*;

    typedef struct packed {
        logic [7:0]       raw;
        logic             eos;
        logic             typed;
        logic [7:0]       last_char;
        logic [LEN_W-1:0] last_len;
    } t_row;

    localparam int NUM_ROWS = 21;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    logic             row_typed;
    logic [7:0]       row_last_char;
    logic [LEN_W-1:0] row_last_len;

    t_out_item escaped_q [$];
    int        run_length;
    int        errors;
    int        bytes_taken;
    int        chars_checked;
    int        in_gap_pct;
    int        out_stall_pct;
    bit        hold_off_req;
    t_row      directed_rows [NUM_ROWS];

    json_string_escaper_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(4 * 3_000_000);
        $display("testbench NOT OK");
        $finish;
    end

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + 8'(nib);
        end
        return 8'h61 + 8'(nib) - 8'd10;
    endfunction

    task automatic escape_byte(input t_in_item it, input logic typed,
                               input logic [7:0] tchar, input logic [LEN_W-1:0] tlen);
        logic [7:0] seq [0:5];
        logic [7:0] letter;
        t_out_item  r;
        int         n;
        letter = 8'h00;
        case (it.raw_byte)
            CH_QUOTE:  letter = CH_QUOTE;
            CH_SLASH:  letter = CH_SLASH;
            CH_BSLASH: letter = CH_BSLASH;
            CH_BS:     letter = CH_LOW_B;
            CH_FF:     letter = CH_LOW_F;
            CH_NL:     letter = CH_LOW_N;
            CH_CR:     letter = CH_LOW_R;
            CH_TAB:    letter = CH_LOW_T;
            default:   letter = 8'h00;
        endcase
        if (letter != 8'h00) begin
            seq[0] = CH_BSLASH;
            seq[1] = letter;
            n = 2;
        end else if (it.raw_byte < CTRL_LIMIT) begin
            seq[0] = CH_BSLASH;
            seq[1] = CH_LOW_U;
            seq[2] = CH_ZERO;
            seq[3] = CH_ZERO;
            seq[4] = hex_ascii(it.raw_byte[7:4]);
            seq[5] = hex_ascii(it.raw_byte[3:0]);
            n = 6;
        end else begin
            seq[0] = it.raw_byte;
            n = 1;
        end
        for (int k = 0; k < n; k++) begin
            if (run_length < LEN_CAP) begin
                run_length++;
            end
            r.out_char = seq[k];
            r.run_last = (k == n - 1);
            r.string_done = (k == n - 1) && it.end_of_string;
            r.escaped_length = LEN_W'(run_length);
            if (typed && k == n - 1) begin
                r.out_char = tchar;
                r.escaped_length = tlen;
            end
            escaped_q.push_back(r);
        end
        if (it.end_of_string) begin
            run_length = 0;
        end
    endtask

    always @(posedge i_clk) begin : check_blk
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                chars_checked++;
                if (escaped_q.size() == 0) begin
                    $error("unexpected escaped byte %h", o_out_data.out_char);
                    errors++;
                end else begin
                    want = escaped_q.pop_front();
                    if (o_out_data.out_char !== want.out_char) begin
                        $error("out_char: expected %h, got %h",
                               want.out_char, o_out_data.out_char);
                        errors++;
                    end
                    if (o_out_data.run_last !== want.run_last) begin
                        $error("run_last: expected %b, got %b",
                               want.run_last, o_out_data.run_last);
                        errors++;
                    end
                    if (o_out_data.string_done !== want.string_done) begin
                        $error("string_done: expected %b, got %b",
                               want.string_done, o_out_data.string_done);
                        errors++;
                    end
                    if (o_out_data.escaped_length !== want.escaped_length) begin
                        $error("escaped_length: expected %0d, got %0d",
                               want.escaped_length, o_out_data.escaped_length);
                        errors++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                bytes_taken++;
                escape_byte(i_in_data, row_typed, row_last_char, row_last_len);
            end
        end
    end

    initial begin : receiver
        @(posedge i_rst_n);
        forever begin
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (80) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else if ($urandom_range(0, 99) < out_stall_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] raw, input logic eos, input logic typed,
                             input logic [7:0] tchar, input logic [LEN_W-1:0] tlen);
        if ($urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{raw_byte: raw, end_of_string: eos};
        row_typed <= typed;
        row_last_char <= tchar;
        row_last_len <= tlen;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 4))
            0: return 8'($urandom_range(8'h20, 8'h7E));
            1: begin
                case ($urandom_range(0, 7))
                    0: return CH_QUOTE;
                    1: return CH_SLASH;
                    2: return CH_BSLASH;
                    3: return CH_BS;
                    4: return CH_FF;
                    5: return CH_NL;
                    6: return CH_CR;
                    default: return CH_TAB;
                endcase
            end
            2: return 8'($urandom_range(0, 31));
            3: return 8'($urandom_range(8'h80, 8'hFF));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_string(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(pick_byte(), i == len - 1, 1'b0, 8'h00, '0);
        end
    endtask

    initial begin : stimulus
        int wait_cycles;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        row_typed = 1'b0;
        row_last_char = 8'h00;
        row_last_len = '0;
        run_length = 0;
        errors = 0;
        bytes_taken = 0;
        chars_checked = 0;
        hold_off_req = 1'b0;
        in_gap_pct = 20;
        out_stall_pct = 20;
        directed_rows = '{
            '{8'h41, 1'b0, 1'b1, 8'h41, 15'd1},
            '{8'h22, 1'b0, 1'b1, 8'h22, 15'd3},
            '{8'h2F, 1'b0, 1'b1, 8'h2F, 15'd5},
            '{8'h5C, 1'b0, 1'b1, 8'h5C, 15'd7},
            '{8'h08, 1'b0, 1'b1, 8'h62, 15'd9},
            '{8'h0C, 1'b0, 1'b1, 8'h66, 15'd11},
            '{8'h0A, 1'b0, 1'b1, 8'h6E, 15'd13},
            '{8'h0D, 1'b0, 1'b1, 8'h72, 15'd15},
            '{8'h09, 1'b0, 1'b1, 8'h74, 15'd17},
            '{8'h00, 1'b0, 1'b1, 8'h30, 15'd23},
            '{8'h1F, 1'b0, 1'b1, 8'h66, 15'd29},
            '{8'h20, 1'b0, 1'b1, 8'h20, 15'd30},
            '{8'hFF, 1'b1, 1'b1, 8'hFF, 15'd31},
            '{8'h00, 1'b1, 1'b1, 8'h30, 15'd6},
            '{8'h7F, 1'b1, 1'b1, 8'h7F, 15'd1},
            '{8'h80, 1'b0, 1'b0, 8'h00, 15'd0},
            '{8'h1B, 1'b0, 1'b1, 8'h62, 15'd7},
            '{8'h10, 1'b1, 1'b1, 8'h30, 15'd13},
            '{8'h01, 1'b0, 1'b1, 8'h31, 15'd6},
            '{8'hC3, 1'b0, 1'b0, 8'h00, 15'd0},
            '{8'hA9, 1'b1, 1'b0, 8'h00, 15'd0}
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].raw, directed_rows[i].eos, directed_rows[i].typed,
                      directed_rows[i].last_char, directed_rows[i].last_len);
        end

        // Long output stall while input keeps coming, so the queue fills and backs up.
        hold_off_req = 1'b1;
        in_gap_pct = 0;
        send_string(16);
        i_in_valid <= 1'b0;
        while (escaped_q.size() != 0) @(negedge i_clk);

        for (int s = 0; s < 36; s++) begin
            case ($urandom_range(0, 2))
                0: in_gap_pct = 0;
                1: in_gap_pct = 10;
                default: in_gap_pct = 30;
            endcase
            case ($urandom_range(0, 2))
                0: out_stall_pct = 0;
                1: out_stall_pct = 10;
                default: out_stall_pct = 30;
            endcase
            send_string($urandom_range(1, 12));
        end

        in_gap_pct = 0;
        out_stall_pct = 0;
        for (int s = 0; s < 6; s++) begin
            send_string($urandom_range(3, 10));
        end
        i_in_valid <= 1'b0;

        wait_cycles = 0;
        while (escaped_q.size() != 0 && wait_cycles < 200_000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (escaped_q.size() != 0) begin
            $error("%0d escaped bytes never arrived", escaped_q.size());
            errors++;
        end
        repeat (10) @(posedge i_clk);

        $display("Sent %0d raw bytes and checked %0d escaped bytes.", bytes_taken,
                 chars_checked);
        $display("Covered every escape class, string ends, random stalls and a full queue.");
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
